// File: rtl/core/kpsm_pkg.sv
package kpsm_pkg;

  // one input beat: sampled columns and timer tick
  typedef struct packed {
    logic [2:0] column_lines;
    logic       tick;
  } in_beat_t;

  // one result beat
  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_down;
    logic       tone_start;
    logic       tone_stop;
    logic [3:0] tone_index;
    logic       tap_event;
    logic       new_character;
    logic [7:0] character;
  } out_beat_t;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgBounceTicks = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTapTimeout  = 1'b1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgDataW-1:0] BounceTicksRst = 16'd20;
  localparam logic [CfgDataW-1:0] TapTimeoutRst  = 16'd1000;

  // key codes in scan order 1 2 3 / 4 5 6 / 7 8 9 / * 0 #
  localparam logic [3:0] KeyOne   = 4'd0;
  localparam logic [3:0] KeyTwo   = 4'd1;
  localparam logic [3:0] KeyNine  = 4'd8;
  localparam logic [3:0] KeyStar  = 4'd9;
  localparam logic [3:0] KeyZero  = 4'd10;
  localparam logic [3:0] KeyHash  = 4'd11;

  // ascii codes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChHash  = 8'h23;

  // first letter of a letter key
  function automatic logic [7:0] letter_base(input logic [3:0] key);
    logic [7:0] base;
    case (key)
      4'd1:    base = 8'h41; // A
      4'd2:    base = 8'h44; // D
      4'd3:    base = 8'h47; // G
      4'd4:    base = 8'h4A; // J
      4'd5:    base = 8'h4D; // M
      4'd6:    base = 8'h50; // P
      4'd7:    base = 8'h54; // T
      4'd8:    base = 8'h57; // W
      default: base = 8'h00;
    endcase
    return base;
  endfunction

  // entries in a letter key's list, digit included
  function automatic logic [2:0] letter_len(input logic [3:0] key);
    logic [2:0] len;
    case (key)
      4'd6, 4'd8: len = 3'd5;
      default:    len = 3'd4;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/core/keypad_scan_multitap_top.sv
// latency: a result beat is registered and shows on out_data_o in the cycle after its input beat is accepted
// throughput: one beat per cycle while in_stall_o is low; single pass of scan and tap logic into the result register
// in_stall_o is high only while the result register is full and out_stall_i holds it
// reset (rst_ni low, asynchronous): row 0 scan, no row driven, timers and taps cleared,
//   bounce_ticks back to 20 and tap_timeout_ticks back to 1000
module keypad_scan_multitap_top #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  kpsm_pkg::in_beat_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output kpsm_pkg::out_beat_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [kpsm_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [kpsm_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  localparam int unsigned CmpW = (TIMER_WIDTH > kpsm_pkg::CfgDataW) ?
                                 TIMER_WIDTH : kpsm_pkg::CfgDataW;

  // scan phases; row phases equal the row number
  localparam logic [2:0] ScanRow3    = 3'd3;
  localparam logic [2:0] ScanArm     = 3'd4;
  localparam logic [2:0] ScanSettle  = 3'd5;
  localparam logic [2:0] ScanHeld    = 3'd6;
  localparam logic [2:0] ScanRelease = 3'd7;

  // tap phases
  localparam logic [1:0] TapIdle  = 2'd0;
  localparam logic [1:0] TapCount = 2'd1;
  localparam logic [1:0] TapWait  = 2'd2;

  logic [kpsm_pkg::CfgDataW-1:0] bounce_q, timeout_q;
  logic [2:0]             scan_q, scan_d;
  logic [1:0]             row_q, row_d;
  logic [3:0]             latch_q, latch_d;
  logic [TIMER_WIDTH-1:0] deb_q, deb_d, deb_t;
  logic [TIMER_WIDTH-1:0] idl_q, idl_d, idl_t;
  logic                   held_q, held_d;
  logic [1:0]             tap_q, tap_d;
  logic [2:0]             tc_q, tc_d, tc_inc, tc_adj, lim;
  logic [3:0]             cur_q, cur_d, last_q, last_d;
  logic                   rb_q, rb_d;
  logic                   out_valid_q;
  kpsm_pkg::out_beat_t    out_q, res;
  logic                   accept, idle, bounce_done;
  logic [2:0]             cols, pos;
  logic [3:0]             base_old, base_new, new_key, key;
  logic                   tone_start, tone_stop, tap_ev, new_ch;
  logic [3:0]             tone_idx;
  logic [7:0]             ch_pick;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cols = in_data_i.column_lines;
  assign idle = (cols == 3'b111);

  // timers count first, saturating
  assign deb_t = (in_data_i.tick && deb_q != '1) ? deb_q + 1'b1 : deb_q;
  assign idl_t = (in_data_i.tick && idl_q != '1) ? idl_q + 1'b1 : idl_q;
  assign bounce_done = CmpW'(deb_t) >= CmpW'(bounce_q);

  assign base_old = ({2'b00, row_q} << 1) + {2'b00, row_q};
  assign base_new = ({2'b00, row_d} << 1) + {2'b00, row_d};

  // scanner and debounce
  always_comb begin
    scan_d     = scan_q;
    row_d      = row_q;
    latch_d    = latch_q;
    deb_d      = deb_t;
    held_d     = held_q;
    tone_start = 1'b0;
    tone_stop  = 1'b0;
    tone_idx   = 4'd0;
    case (scan_q)
      3'd0, 3'd1, 3'd2, ScanRow3: begin
        if (idle) begin
          row_d   = scan_q[1:0];
          latch_d = ~(4'b0001 << scan_q[1:0]);
          scan_d  = {1'b0, scan_q[1:0] + 2'd1};
        end else begin
          scan_d = ScanArm;
        end
      end
      ScanArm: begin
        deb_d  = '0;
        scan_d = ScanSettle;
      end
      ScanSettle: begin
        if (bounce_done) begin
          if (idle) begin
            scan_d = 3'd0;
          end else begin
            held_d     = 1'b1;
            tone_start = 1'b1;
            tone_idx   = !cols[1] ? base_old :
                         !cols[0] ? base_old + 4'd1 : base_old + 4'd2;
            scan_d     = ScanHeld;
          end
        end
      end
      ScanHeld: begin
        if (idle) begin
          deb_d  = '0;
          scan_d = ScanRelease;
        end
      end
      ScanRelease: begin
        if (bounce_done) begin
          if (idle) begin
            tone_stop = 1'b1;
            held_d    = 1'b0;
            scan_d    = 3'd0;
          end else begin
            scan_d = ScanHeld;
          end
        end
      end
      default: scan_d = 3'd0;
    endcase
  end

  assign new_key = !cols[0] ? base_new :
                   !cols[1] ? base_new + 4'd1 : base_new + 4'd2;
  assign tc_inc  = (tc_q == 3'd7) ? tc_q : tc_q + 3'd1;
  assign key     = (cur_q > kpsm_pkg::KeyHash) ? kpsm_pkg::KeyHash : cur_q;

  // tap count wrap and character choice
  always_comb begin
    lim     = kpsm_pkg::letter_len(key);
    tc_adj  = tc_inc;
    pos     = 3'd0;
    ch_pick = kpsm_pkg::ChHash;
    if (key == kpsm_pkg::KeyZero) begin
      if (tc_inc > 3'd2 || tc_inc == 3'd0) tc_adj = 3'd1;
      ch_pick = (tc_adj == 3'd1) ? kpsm_pkg::ChSpace : kpsm_pkg::ChZero;
    end else if (key >= kpsm_pkg::KeyTwo && key <= kpsm_pkg::KeyNine) begin
      if (tc_inc == 3'd0 || tc_inc > lim) tc_adj = 3'd1;
      pos = tc_adj - 3'd1;
      ch_pick = (pos == lim - 3'd1) ? kpsm_pkg::ChOne + {4'd0, key} :
                kpsm_pkg::letter_base(key) + {5'd0, pos};
    end else if (key == kpsm_pkg::KeyOne) begin
      ch_pick = kpsm_pkg::ChOne;
    end else if (key == kpsm_pkg::KeyStar) begin
      ch_pick = kpsm_pkg::ChStar;
    end
  end

  // multi-tap sequencer
  always_comb begin
    tap_d  = tap_q;
    tc_d   = tc_q;
    cur_d  = cur_q;
    last_d = last_q;
    rb_d   = rb_q;
    idl_d  = idl_t;
    tap_ev = 1'b0;
    new_ch = 1'b0;
    case (tap_q)
      TapIdle: begin
        if (held_d) begin
          tap_d = TapCount;
          cur_d = new_key;
          rb_d  = 1'b0;
          if (tc_q != 3'd0 && (last_q != new_key ||
              CmpW'(idl_t) >= CmpW'(timeout_q))) begin
            rb_d   = 1'b1;
            last_d = new_key;
            tc_d   = 3'd0;
          end
        end else begin
          last_d = cur_q;
        end
      end
      TapCount: begin
        tc_d  = tc_inc;
        tap_d = TapWait;
        if (held_d) begin
          tap_ev = 1'b1;
          new_ch = rb_q;
          tc_d   = tc_adj;
        end
      end
      TapWait: begin
        if (!held_d) begin
          idl_d = '0;
          tap_d = TapIdle;
        end
      end
      default: tap_d = TapIdle;
    endcase
  end

  // result beat; character only goes out with a tap
  always_comb begin
    res               = '0;
    res.row_drive     = latch_d;
    res.key_down      = held_d;
    res.tone_start    = tone_start;
    res.tone_stop     = tone_stop;
    res.tone_index    = tone_idx;
    res.tap_event     = tap_ev;
    res.new_character = new_ch;
    res.character     = tap_ev ? ch_pick : 8'd0;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounce_q  <= kpsm_pkg::BounceTicksRst;
      timeout_q <= kpsm_pkg::TapTimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kpsm_pkg::CfgBounceTicks: bounce_q  <= cfg_wdata_i;
        kpsm_pkg::CfgTapTimeout:  timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // state update per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= 3'd0;
      row_q   <= 2'd0;
      latch_q <= 4'hF;
      deb_q   <= '0;
      idl_q   <= '0;
      held_q  <= 1'b0;
      tap_q   <= TapIdle;
      tc_q    <= 3'd0;
      cur_q   <= 4'd0;
      last_q  <= 4'd0;
      rb_q    <= 1'b0;
    end else if (accept) begin
      scan_q  <= scan_d;
      row_q   <= row_d;
      latch_q <= latch_d;
      deb_q   <= deb_d;
      idl_q   <= idl_d;
      held_q  <= held_d;
      tap_q   <= tap_d;
      tc_q    <= tc_d;
      cur_q   <= cur_d;
      last_q  <= last_d;
      rb_q    <= rb_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

endmodule

// File: rtl/core/kpsm_checker.sv
module kpsm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input kpsm_pkg::out_beat_t               out_data_o
);

  // a press beat reports the key as held, a release beat as free
  a_start_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tone_start |-> out_data_o.key_down && !out_data_o.tone_stop)
    else $error("tone start without held key");

  a_stop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tone_stop |-> !out_data_o.key_down)
    else $error("tone stop while key held");

  // taps only happen while a key is held
  a_tap_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tap_event |-> out_data_o.key_down)
    else $error("tap without held key");

  // at most one row driven low
  a_one_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones(out_data_o.row_drive) >= 3)
    else $error("more than one row driven");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

endmodule

bind keypad_scan_multitap_top kpsm_checker u_kpsm_checker (.*);

// File: bench/tb_keypad_scan_multitap_top.sv
module tb_keypad_scan_multitap_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned NumPhases = 10;
  localparam logic [15:0] TimerMax = 16'hFFFF;
  localparam logic [2:0] NoKey = 3'b111;
  localparam logic [kpsm_pkg::CfgIdxW-1:0] IdxBounce  = kpsm_pkg::CfgBounceTicks;
  localparam logic [kpsm_pkg::CfgIdxW-1:0] IdxTimeout = kpsm_pkg::CfgTapTimeout;

  // scan phases: 0..3 drive a row, then settle, press wait, held, release wait
  localparam logic [2:0] ScanRow0    = 3'd0;
  localparam logic [2:0] ScanRow1    = 3'd1;
  localparam logic [2:0] ScanRow2    = 3'd2;
  localparam logic [2:0] ScanRow3    = 3'd3;
  localparam logic [2:0] ScanSettle  = 3'd4;
  localparam logic [2:0] ScanPress   = 3'd5;
  localparam logic [2:0] ScanHeld    = 3'd6;
  localparam logic [2:0] ScanRelease = 3'd7;

  // multi-tap phases
  localparam logic [1:0] TapIdle  = 2'd0;
  localparam logic [1:0] TapCount = 2'd1;
  localparam logic [1:0] TapWait  = 2'd2;

  typedef enum logic {StepBeat, StepReg} dir_kind_e;

  typedef struct packed {
    dir_kind_e                         kind;
    logic [kpsm_pkg::CfgIdxW-1:0]      reg_idx;
    logic [kpsm_pkg::CfgDataW-1:0]     value;
    logic [2:0]                        cols;
    logic                              tick;
    logic                              typed;
    logic [3:0]                        exp_rows;
    logic                              exp_held;
    logic                              exp_tap;
    logic [7:0]                        exp_char;
  } dir_step_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  kpsm_pkg::in_beat_t                in_data_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  kpsm_pkg::out_beat_t               out_data_o;
  logic                              cfg_we_i = 1'b0;
  logic [kpsm_pkg::CfgIdxW-1:0]      cfg_index_i = '0;
  logic [kpsm_pkg::CfgDataW-1:0]     cfg_wdata_i = '0;

  // keypad model state and its copy of the registers
  logic [2:0]  scan_phase = ScanRow0;
  logic [1:0]  active_row = 2'd0;
  logic [3:0]  row_latch = 4'hF;
  logic [15:0] debounce_cnt = '0;
  logic        held = 1'b0;
  logic [1:0]  tap_phase = TapIdle;
  logic [2:0]  tap_count = '0;
  logic [3:0]  cur_key = '0;
  logic [3:0]  prev_key = '0;
  logic [15:0] idle_cnt = '0;
  logic        run_break = 1'b0;
  logic [15:0] bounce_limit = kpsm_pkg::BounceTicksRst;
  logic [15:0] tap_timeout = kpsm_pkg::TapTimeoutRst;

  // first letter of keys 2..9
  logic [7:0] first_letter [1:8] = '{"A", "D", "G", "J", "M", "P", "T", "W"};

  kpsm_pkg::out_beat_t key_results_q [$];
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // directed beats: scan rows, key 1 first tap, key 2 new run, second tap on key 2
  dir_step_t dir_steps [25] = '{
    '{StepBeat, IdxBounce,  16'd0, NoKey,  1'b0, 1'b1, 4'b1110, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, NoKey,  1'b1, 1'b1, 4'b1101, 1'b0, 1'b0, 8'h00},
    '{StepReg,  IdxBounce,  16'd0, NoKey,  1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepReg,  IdxTimeout, 16'd2, NoKey,  1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, NoKey,  1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, NoKey,  1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, NoKey,  1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, 3'b000, 1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, 3'b000, 1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, 3'b000, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, 3'b000, 1'b1, 1'b1, 4'b1110, 1'b1, 1'b1,
      kpsm_pkg::ChOne},
    '{StepBeat, IdxBounce,  16'd0, NoKey,  1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, NoKey,  1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, 3'b101, 1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, 3'b101, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, 3'b101, 1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, 3'b101, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, NoKey,  1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, NoKey,  1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, 3'b101, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, 3'b101, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, 3'b101, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, 3'b101, 1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, NoKey,  1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00},
    '{StepBeat, IdxBounce,  16'd0, NoKey,  1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00}
  };

  // register settings per random phase, extremes included
  logic [15:0] phase_bounce [NumPhases] =
    '{16'd0, 16'd1, 16'd0, 16'd2, 16'd65535, 16'd20, 16'd3, 16'd0, 16'd1, 16'd5};
  logic [15:0] phase_timeout [NumPhases] =
    '{16'd0, 16'd4, 16'd65535, 16'd10, 16'd1000, 16'd1000, 16'd0, 16'd2, 16'd65535, 16'd25};
  int unsigned phase_len [NumPhases] =
    '{120, 110, 120, 110, 30, 120, 110, 110, 120, 110};

  keypad_scan_multitap_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("keypad_scan_multitap_top: mismatch");
      $finish;
    end
  end

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int short_or_long(int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one polling pass: scanner, debounce and multi-tap text entry
  function automatic kpsm_pkg::out_beat_t keypad_pass(kpsm_pkg::in_beat_t b);
    kpsm_pkg::out_beat_t res;
    logic [2:0] cols;
    logic       idle;
    logic [3:0] row_base;
    logic [7:0] digit;
    logic [2:0] list_len;
    cols = b.column_lines;
    idle = (cols == NoKey);
    res = '0;
    // timers count first, a clear later in the pass wins
    if (b.tick) begin
      if (debounce_cnt != TimerMax) debounce_cnt = debounce_cnt + 16'd1;
      if (idle_cnt != TimerMax) idle_cnt = idle_cnt + 16'd1;
    end

    case (scan_phase)
      ScanRow0, ScanRow1, ScanRow2, ScanRow3: begin
        if (idle) begin
          active_row = scan_phase[1:0];
          row_latch = ~(4'b0001 << scan_phase[1:0]);
          scan_phase = {1'b0, scan_phase[1:0] + 2'd1};
        end else begin
          scan_phase = ScanSettle;
        end
      end
      ScanSettle: begin
        debounce_cnt = '0;
        scan_phase = ScanPress;
      end
      ScanPress: begin
        if (debounce_cnt >= bounce_limit) begin
          if (idle) begin
            scan_phase = ScanRow0;
          end else begin
            row_base = {2'b00, active_row} * 4'd3;
            held = 1'b1;
            res.tone_start = 1'b1;
            res.tone_index = !cols[1] ? row_base : !cols[0] ? row_base + 4'd1 : row_base + 4'd2;
            scan_phase = ScanHeld;
          end
        end
      end
      ScanHeld: begin
        if (idle) begin
          debounce_cnt = '0;
          scan_phase = ScanRelease;
        end
      end
      ScanRelease: begin
        if (debounce_cnt >= bounce_limit) begin
          if (idle) begin
            res.tone_stop = 1'b1;
            held = 1'b0;
            scan_phase = ScanRow0;
          end else begin
            scan_phase = ScanHeld;
          end
        end
      end
      default: scan_phase = ScanRow0;
    endcase

    case (tap_phase)
      TapIdle: begin
        if (held) begin
          // key number uses column 0 first, unlike the tone index
          row_base = {2'b00, active_row} * 4'd3;
          tap_phase = TapCount;
          cur_key = !cols[0] ? row_base : !cols[1] ? row_base + 4'd1 : row_base + 4'd2;
          run_break = 1'b0;
          if (tap_count != 3'd0 && (prev_key != cur_key || idle_cnt >= tap_timeout)) begin
            run_break = 1'b1;
            prev_key = cur_key;
            tap_count = '0;
          end
        end else begin
          prev_key = cur_key;
        end
      end
      TapCount: begin
        if (tap_count < 3'd7) tap_count = tap_count + 3'd1;
        tap_phase = TapWait;
        if (held) begin
          res.tap_event = 1'b1;
          res.new_character = run_break;
          if (cur_key == kpsm_pkg::KeyZero) begin
            // space and zero alternate
            if (tap_count > 3'd2 || tap_count == 3'd0) tap_count = 3'd1;
            res.character = (tap_count == 3'd1) ? kpsm_pkg::ChSpace : kpsm_pkg::ChZero;
          end else if (cur_key >= kpsm_pkg::KeyTwo && cur_key <= kpsm_pkg::KeyNine) begin
            // letters then the digit, wrapping back to the first letter
            digit = kpsm_pkg::ChOne + {4'b0000, cur_key};
            list_len = (digit == "7" || digit == "9") ? 3'd5 : 3'd4;
            if (tap_count == 3'd0 || tap_count > list_len) tap_count = 3'd1;
            res.character = (tap_count == list_len) ? digit :
                            first_letter[cur_key] + {5'b00000, tap_count} - 8'd1;
          end else if (cur_key == kpsm_pkg::KeyStar) begin
            res.character = kpsm_pkg::ChStar;
          end else if (cur_key == kpsm_pkg::KeyHash) begin
            res.character = kpsm_pkg::ChHash;
          end else begin
            res.character = kpsm_pkg::ChOne;
          end
        end
      end
      TapWait: begin
        if (!held) begin
          idle_cnt = '0;
          tap_phase = TapIdle;
        end
      end
      default: tap_phase = TapIdle;
    endcase

    res.row_drive = row_latch;
    res.key_down = held;
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("ERROR: %s", msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] exp);
    if (got !== exp) begin
      flag_mismatch($sformatf("result %0d %s got %h exp %h", results_seen, name, got, exp));
    end
  endtask

  // result side: random stall, calm stretches, and long hold-offs
  initial begin
    int stall_left;
    int hold_left;
    int holds_taken;
    stall_left = 0;
    hold_left = 0;
    holds_taken = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_taken < 2 && results_seen >= (holds_taken + 1) * 450) begin
        hold_left = 80;
        holds_taken++;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        stall_left = ((cycle_count / 300) % 4 == 2) ? 0 : short_or_long(75);
        if (stall_left != 0) begin
          out_stall_i <= 1'b1;
          stall_left--;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(negedge clk_i) begin
    kpsm_pkg::out_beat_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (key_results_q.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        exp = key_results_q.pop_front();
        check_field("row_drive", 8'(out_data_o.row_drive), 8'(exp.row_drive));
        check_field("key_down", 8'(out_data_o.key_down), 8'(exp.key_down));
        check_field("tone_start", 8'(out_data_o.tone_start), 8'(exp.tone_start));
        check_field("tone_stop", 8'(out_data_o.tone_stop), 8'(exp.tone_stop));
        check_field("tone_index", 8'(out_data_o.tone_index), 8'(exp.tone_index));
        check_field("tap_event", 8'(out_data_o.tap_event), 8'(exp.tap_event));
        check_field("new_character", 8'(out_data_o.new_character), 8'(exp.new_character));
        check_field("character", out_data_o.character, exp.character);
      end
      results_seen++;
    end
  end

  // offer one beat, wait for it to be taken, record what it should produce
  task automatic send_beat(input logic [2:0] cols, input logic tick,
                           input bit typed = 1'b0,
                           input kpsm_pkg::out_beat_t typed_exp = '0);
    kpsm_pkg::in_beat_t  b;
    kpsm_pkg::out_beat_t predicted;
    int        gap;
    bit        fire;
    b.column_lines = cols;
    b.tick = tick;
    gap = ((beats_sent / 100) % 4 == 3) ? 0 : short_or_long(65);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    fire = 1'b0;
    while (!fire) begin
      @(negedge clk_i);
      fire = !in_stall_o;
      @(posedge clk_i);
    end
    predicted = keypad_pass(b);
    key_results_q.push_back(typed ? typed_exp : predicted);
    beats_sent++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (key_results_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [kpsm_pkg::CfgIdxW-1:0] idx,
                           input logic [kpsm_pkg::CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == kpsm_pkg::CfgBounceTicks) bounce_limit = val;
    else tap_timeout = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic idle_run(int n, int tick_pct);
    repeat (n) send_beat(NoKey, chance(tick_pct));
  endtask

  // hold a key until the press is debounced and the tap lands, with some bounce
  task automatic press_key(logic [2:0] pat);
    int n;
    n = 0;
    while (!held && n < 60) begin
      send_beat(chance(8) ? NoKey : pat, chance(75));
      n++;
    end
    repeat ($urandom_range(1, 4)) send_beat(pat, chance(50));
  endtask

  task automatic release_key(logic [2:0] pat);
    int n;
    n = 0;
    while (held && n < 60) begin
      send_beat(chance(8) ? pat : NoKey, chance(75));
      n++;
    end
  endtask

  initial begin
    kpsm_pkg::out_beat_t exp;
    logic [2:0]  pat;
    logic [2:0]  last_pat;
    logic [1:0]  last_row;
    bit          have_key;
    int unsigned phase_start;
    int          r;
    int          n;
    last_pat = NoKey;
    last_row = 2'd0;
    have_key = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == StepReg) begin
        wait_drain();
        write_reg(dir_steps[i].reg_idx, dir_steps[i].value);
      end else if (dir_steps[i].typed) begin
        exp = '0;
        exp.row_drive = dir_steps[i].exp_rows;
        exp.key_down = dir_steps[i].exp_held;
        exp.tap_event = dir_steps[i].exp_tap;
        exp.character = dir_steps[i].exp_char;
        send_beat(dir_steps[i].cols, dir_steps[i].tick, 1'b1, exp);
      end else begin
        send_beat(dir_steps[i].cols, dir_steps[i].tick);
      end
    end

    // random part: key presses with random content, some noise and broken presses
    for (int p = 0; p < NumPhases; p++) begin
      wait_drain();
      write_reg(kpsm_pkg::CfgBounceTicks, phase_bounce[p]);
      write_reg(kpsm_pkg::CfgTapTimeout, phase_timeout[p]);
      phase_start = beats_sent;
      while (beats_sent - phase_start < phase_len[p]) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          repeat ($urandom_range(1, 8)) send_beat(3'($urandom_range(0, 7)), chance(50));
        end else begin
          if (r < 60 && have_key) begin
            // same key again, either quickly or after many ticks
            if (chance(50)) idle_run($urandom_range(0, 3), 10);
            else idle_run($urandom_range(2, 20), 85);
            n = 0;
            while (active_row != last_row && n < 8) begin
              send_beat(NoKey, chance(10));
              n++;
            end
            pat = last_pat;
          end else begin
            idle_run($urandom_range(0, 7), 50);
            if (chance(70)) pat = 3'b111 ^ (3'b001 << $urandom_range(0, 2));
            else pat = 3'($urandom_range(0, 6));
          end
          press_key(pat);
          last_row = active_row;
          last_pat = pat;
          have_key = 1'b1;
          release_key(pat);
        end
      end
    end

    wait_drain();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("keypad_scan_multitap_top: match");
    end else begin
      $display("keypad_scan_multitap_top: mismatch");
    end
    $finish;
  end

endmodule
